>>> rtl/core/apf_pkg.sv
// Package for the articulation point finder: sizes, command codes, state type.
// No dependencies.
`timescale 1ns / 1ps
package apf_pkg;
  localparam int MaxVertices = 64;
  localparam int MaxEdges    = 256;
  localparam int VW = $clog2(MaxVertices);
  localparam int EW = $clog2(MaxEdges);

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_RUN   = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CLR, ST_HEAD, ST_TOP, ST_EDGE, ST_TGT, ST_POP, ST_POPW,
    ST_SCAN, ST_EMIT
  } state_t;

  localparam logic [0:0] REG_VCOUNT = 1'd0;
endpackage

>>> rtl/core/articulation_point_finder.sv
// Top level of the articulation point finder: edge store, DFS sequencer, emitter.
// Depends on apf_pkg.
`timescale 1ns / 1ps
// Usage:
//  in_tdata beats carry a command. A load beat adds one directed edge: the
//  beat is accepted, then in_tready drops for one cycle while the edge is
//  committed; with the store full, the edge is dropped and flagged. A clear
//  beat empties the store, then nulls every list head before the next beat is
//  taken. A run beat starts a depth-first walk from vertex 0 that reads the
//  edge and vertex memories one access at a time; no further input is taken
//  until the run's results are all delivered. A run has a setup step, the walk
//  over each visited vertex and the edges leaving it, then a scan over the
//  vertices in use that emits the result beats one at a time.
//  out beats give cut vertices in ascending order, last on the final one, or
//  one beat with found 0 when none exist. A low out_tready holds the output
//  register and the scan. Reset empties the graph; after reset the block
//  nulls every list head before it accepts beats.
//  vertex_count is written over the cfg port at address 0.
module articulation_point_finder import apf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // cmd[1:0], from_vertex[7:2], to_vertex[13:8]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // cut_vertex[5:0], found[6], edges_dropped[7]
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  // Memories.
  logic [EW:0]   head_mem [MaxVertices];
  logic [EW:0]   next_mem [MaxEdges];
  logic [VW-1:0] tgt_mem  [MaxEdges];
  logic [VW-1:0] ord_mem  [MaxVertices];
  logic [VW-1:0] low_mem  [MaxVertices];
  logic [VW:0]   par_mem  [MaxVertices];
  logic [EW:0]   stke_mem [MaxVertices];
  logic [VW-1:0] stkv_mem [MaxVertices];
  logic [MaxVertices-1:0] visit_r, cut_r;

  state_t state_r, state_nxt;
  logic [6:0]  vcount_r;
  logic [EW:0] used_r;
  logic        ovf_r;
  logic [VW:0] sp_r, cnt_r, rootch_r;
  logic [VW-1:0] clr_r;
  logic [VW-1:0] v_r, t_r, scan_r;
  logic [VW-1:0] par_vtx;
  logic [EW:0]   e_r;
  logic [VW-1:0] lowv_r;
  logic [VW:0]   parv_r;
  logic [6:0]    n_eff;
  logic          in_acc, out_acc;
  cmd_t          cmd;
  logic [VW-1:0] fv, tv;

  assign cmd = cmd_t'(in_tdata[1:0]);
  assign fv = in_tdata[7:2];
  assign tv = in_tdata[13:8];
  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;
  assign n_eff = (vcount_r == 7'd0) ? 7'd1 :
                 (vcount_r > 7'(MaxVertices)) ? 7'(MaxVertices) : vcount_r;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2:2] == REG_VCOUNT) ? {25'd0, vcount_r} : 32'd0;
  always_ff @(posedge clk) begin
    if (!rst_n) vcount_r <= 7'd1;
    else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[2:2] == REG_VCOUNT)
      vcount_r <= cfg_pwdata[6:0];
  end

  // A load needs the source's old head, so a load beat's head lookup is registered
  // on acceptance and the edge is committed in the cycle after; in_tready drops for that cycle.
  logic ld_pend_r;
  logic [VW-1:0] ld_from_r, ld_to_r;
  logic push_r;

  // Registered read ports.
  logic [EW:0] head_rd, next_rd, stke_rd;
  logic [VW-1:0] tgt_rd, ord_rd, low_rd, stkv_rd;
  logic [VW:0] par_rd;
  logic [VW-1:0] head_a, vtx_a;
  logic [EW-1:0] edge_a;
  logic [VW-1:0] stk_a;
  logic head_we, ord_we, low_we, par_we, stk_we;
  logic [EW:0] head_wd, stke_wd;
  logic [VW-1:0] ord_wd, low_wd, stkv_wd, vtx_wa;
  logic [VW:0] par_wd;

  always_ff @(posedge clk) begin
    if (head_we) head_mem[head_a] <= head_wd;
    head_rd <= head_mem[head_a];
    if (ld_pend_r) begin
      next_mem[used_r[EW-1:0]] <= head_rd;
      tgt_mem[used_r[EW-1:0]]  <= ld_to_r;
    end
    next_rd <= next_mem[edge_a];
    tgt_rd  <= tgt_mem[edge_a];
    if (ord_we) ord_mem[vtx_wa] <= ord_wd;
    if (low_we) low_mem[vtx_wa] <= low_wd;
    if (par_we) par_mem[vtx_wa] <= par_wd;
    ord_rd <= ord_mem[vtx_a];
    low_rd <= low_mem[vtx_a];
    par_rd <= par_mem[vtx_a];
    if (stk_we) begin
      stke_mem[stk_a] <= stke_wd;
      stkv_mem[stk_a] <= stkv_wd;
    end
    stke_rd <= stke_mem[stk_a];
    stkv_rd <= stkv_mem[stk_a];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc && cmd == CMD_CLEAR) state_nxt = ST_CLR;
               else if (in_acc && cmd == CMD_RUN) state_nxt = ST_HEAD;
      ST_CLR:  if (clr_r == VW'(MaxVertices-1)) state_nxt = ST_IDLE;
      ST_HEAD: state_nxt = ST_TOP;
      ST_TOP:  state_nxt = ST_EDGE;
      ST_EDGE: state_nxt = (e_r >= used_r) ? ST_POP : ST_TGT;
      ST_TGT:  state_nxt = ST_TOP;
      ST_POP:  state_nxt = ST_POPW;
      ST_POPW: state_nxt = (sp_r == '0) ? ST_SCAN : ST_TOP;
      ST_SCAN: if (!out_tvalid || out_acc) begin
                 if (7'(scan_r) + 7'd1 >= n_eff || cut_r[scan_r]) state_nxt = ST_EMIT;
               end
      ST_EMIT: if (out_acc) state_nxt = out_tlast ? ST_IDLE : ST_SCAN;
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_tready = (state_r == ST_IDLE) && !ld_pend_r && !out_tvalid;

  // Memory addressing per state.
  always_comb begin
    head_a = ld_pend_r ? ld_from_r : fv;
    head_we = 1'b0; head_wd = used_r;
    edge_a = e_r[EW-1:0];
    vtx_a = v_r; vtx_wa = v_r;
    ord_we = 1'b0; low_we = 1'b0; par_we = 1'b0; stk_we = 1'b0;
    ord_wd = cnt_r[VW-1:0]; low_wd = cnt_r[VW-1:0]; par_wd = {1'b0, v_r};
    stk_a = sp_r[VW-1:0] - VW'(1);
    stke_wd = e_r; stkv_wd = v_r;
    unique case (state_r)
      ST_IDLE: begin
        head_we = ld_pend_r;
        if (in_acc && cmd == CMD_RUN) head_a = '0;
      end
      ST_CLR: begin
        head_a = clr_r; head_we = 1'b1; head_wd = (EW+1)'(MaxEdges);
      end
      ST_HEAD: begin
        // The root gets order 0 and no parent.
        ord_we = 1'b1; low_we = 1'b1; par_we = 1'b1;
        ord_wd = '0; low_wd = '0; par_wd = (VW+1)'(MaxVertices);
      end
      // A freshly pushed vertex starts on its list head, which is still in head_rd.
      ST_TOP: if (push_r) edge_a = head_rd[EW-1:0];
      ST_EDGE: begin
        vtx_a = tgt_rd;
        if (e_r < used_r) begin
          stk_we = 1'b1; stke_wd = next_rd; stkv_wd = v_r;
        end
      end
      ST_TGT: begin
        head_a = t_r;
        if (!visit_r[t_r] && 7'(t_r) < n_eff) begin
          vtx_wa = t_r; ord_we = 1'b1; low_we = 1'b1; par_we = 1'b1;
        end else if (visit_r[t_r] && 7'(t_r) < n_eff && parv_r != {1'b0, t_r}
                     && ord_rd < lowv_r) begin
          low_we = 1'b1; low_wd = ord_rd;
        end
      end
      ST_POP: begin
        stk_a = sp_r[VW-1:0] - VW'(2);
        vtx_a = parv_r[VW-1:0];
      end
      ST_POPW: begin
        vtx_wa = par_vtx;
        if (sp_r != '0 && lowv_r < low_rd) begin
          low_we = 1'b1; low_wd = lowv_r;
        end
      end
      default: ;
    endcase
  end

  // v_r/e_r/lowv_r hold the top frame. Head of the pushed vertex arrives in ST_TOP.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR; clr_r <= '0; used_r <= '0; ovf_r <= 1'b0;
      ld_pend_r <= 1'b0; out_tvalid <= 1'b0; visit_r <= '0; cut_r <= '0;
      sp_r <= '0; push_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ld_pend_r <= in_acc && cmd == CMD_LOAD && used_r != (EW+1)'(MaxEdges);
      if (state_r == ST_CLR) clr_r <= clr_r + VW'(1);
      if (in_acc) begin
        unique case (cmd)
          CMD_LOAD: if (used_r == (EW+1)'(MaxEdges)) ovf_r <= 1'b1;
                    else begin ld_from_r <= fv; ld_to_r <= tv; end
          CMD_CLEAR: begin used_r <= '0; ovf_r <= 1'b0; clr_r <= '0; end
          CMD_RUN: begin
            visit_r <= {{(MaxVertices-1){1'b0}}, 1'b1}; cut_r <= '0;
            v_r <= '0; cnt_r <= (VW+1)'(1); sp_r <= (VW+1)'(1);
            rootch_r <= '0; lowv_r <= '0;
            parv_r <= (VW+1)'(MaxVertices); push_r <= 1'b1; scan_r <= '0;
          end
          default: ;
        endcase
      end
      if (ld_pend_r) used_r <= used_r + (EW+1)'(1);
      unique case (state_r)
        ST_HEAD: begin
          e_r <= head_rd; push_r <= 1'b0;
        end
        ST_TOP: begin
          if (push_r) begin e_r <= head_rd; push_r <= 1'b0; end
        end
        ST_EDGE: begin
          if (e_r < used_r) begin
            t_r <= tgt_rd; e_r <= next_rd;
          end
        end
        ST_TGT: begin
          if (!visit_r[t_r] && 7'(t_r) < n_eff) begin
            visit_r[t_r] <= 1'b1;
            v_r <= t_r; lowv_r <= cnt_r[VW-1:0];
            parv_r <= {1'b0, v_r}; cnt_r <= cnt_r + (VW+1)'(1);
            sp_r <= sp_r + (VW+1)'(1); push_r <= 1'b1;
          end else if (low_we) lowv_r <= ord_rd;
        end
        ST_POP: begin
          sp_r <= sp_r - (VW+1)'(1);
        end
        ST_POPW: if (sp_r != '0) begin
          if (sp_r == (VW+1)'(1)) rootch_r <= rootch_r + (VW+1)'(1);
          else if (lowv_r >= ord_rd) cut_r[par_vtx] <= 1'b1;
          v_r <= par_vtx; e_r <= stke_rd; parv_r <= par_rd;
          lowv_r <= (lowv_r < low_rd) ? lowv_r : low_rd;
        end else if (rootch_r >= (VW+1)'(2)) cut_r[0] <= 1'b1;
        ST_SCAN: if (!out_tvalid || out_acc) begin
          if (7'(scan_r) + 7'd1 >= n_eff || cut_r[scan_r]) begin
            out_tvalid <= 1'b1;
            out_tdata <= {ovf_r, cut_r[scan_r], cut_r[scan_r] ? scan_r : VW'(0)};
            out_tlast <= (7'(scan_r) + 7'd1 >= n_eff) ||
                         (cut_r >> (scan_r + VW'(1))) == '0 || scan_r == VW'(MaxVertices-1);
          end
          scan_r <= scan_r + VW'(1);
        end
        default: ;
      endcase
      if (state_r == ST_EMIT && out_acc) out_tvalid <= 1'b0;
    end
  end

  // The parent frame index is stack slot sp-2; its vertex sits in stkv_mem.
  assign par_vtx = stkv_rd;

  a_sp: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= (VW+1)'(MaxVertices)) else $error("stack overflow");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |-> !in_tready) else $error("ready while busy");
  a_used: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= (EW+1)'(MaxEdges)) else $error("edge count overflow");
endmodule

>>> tb/testbench.sv
// Self-checking testbench for articulation_point_finder: edge loads, clears and
// searches on streams with random idling, checked against an internal graph predictor.
// Depends on apf_pkg and the articulation_point_finder RTL.
`timescale 1ns / 1ps
module testbench import apf_pkg::*; ();

  localparam int CycleLimit = 2000000;
  localparam int SettleCycles = MaxVertices + 40;

  typedef struct packed {
    logic [5:0] cut_vertex;
    logic       found;
    logic       last;
    logic       edges_dropped;
  } cut_beat_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // cmd[1:0], from_vertex[7:2], to_vertex[13:8]
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;  // cut_vertex[5:0], found[6], edges_dropped[7]
  logic        out_tlast;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  articulation_point_finder dut (.*);

  // Graph shadow kept by the predictor.
  int        list_head [MaxVertices];
  int        next_edge [MaxEdges];
  int        edge_dest [MaxEdges];
  int        edges_stored;
  bit        store_overflowed;
  logic [6:0] vcount_reg;

  cut_beat_t expected_cuts[$];
  int        error_count = 0;
  int        cycle_count = 0;
  int        searches_run;
  int        beats_checked = 0;
  int        edges_sent;
  int        stall_left;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d beats still expected", cycle_count,
               expected_cuts.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    error_count++;
  endtask

  function automatic void clear_shadow();
    for (int i = 0; i < MaxVertices; i++) list_head[i] = MaxEdges;
    edges_stored = 0;
    store_overflowed = 0;
  endfunction

  // Iterative DFS with lowest reachable order; queues the cut vertex beats.
  function automatic void predict_cut_vertices();
    int n, counter, sp, root_kids, v, e, p, t, hits;
    bit seen [MaxVertices];
    bit is_cut [MaxVertices];
    int ord [MaxVertices];
    int low [MaxVertices];
    int par [MaxVertices];
    int stk_v [MaxVertices];
    int stk_e [MaxVertices];
    cut_beat_t beat;
    n = (vcount_reg == 0) ? 1 : (vcount_reg > MaxVertices) ? MaxVertices : int'(vcount_reg);
    for (int i = 0; i < MaxVertices; i++) begin
      seen[i] = 0;
      is_cut[i] = 0;
      ord[i] = 0;
      low[i] = 0;
      par[i] = 0;
    end
    counter = 1;
    root_kids = 0;
    seen[0] = 1;
    par[0] = MaxVertices;
    stk_v[0] = 0;
    stk_e[0] = list_head[0];
    sp = 1;
    while (sp > 0) begin
      v = stk_v[sp-1];
      e = stk_e[sp-1];
      if (e >= edges_stored || e >= MaxEdges) begin
        sp--;
        if (sp > 0) begin
          p = stk_v[sp-1];
          if (low[v] < low[p]) low[p] = low[v];
          if (sp == 1) root_kids++;
          else if (low[v] >= ord[p]) is_cut[p] = 1;
        end
        continue;
      end
      stk_e[sp-1] = next_edge[e];
      t = edge_dest[e];
      if (t >= n) continue;
      if (!seen[t]) begin
        if (sp >= MaxVertices) continue;
        seen[t] = 1;
        par[t] = v;
        ord[t] = counter;
        low[t] = counter;
        counter++;
        stk_v[sp] = t;
        stk_e[sp] = list_head[t];
        sp++;
      end else if (par[v] != t && ord[t] < low[v]) begin
        low[v] = ord[t];
      end
    end
    if (root_kids >= 2) is_cut[0] = 1;
    hits = 0;
    for (int i = 0; i < n; i++) begin
      if (is_cut[i]) begin
        beat.cut_vertex = i[5:0];
        beat.found = 1'b1;
        beat.last = 1'b0;
        beat.edges_dropped = store_overflowed;
        expected_cuts.push_back(beat);
        hits++;
      end
    end
    if (hits == 0) begin
      beat = '0;
      beat.last = 1'b1;
      beat.edges_dropped = store_overflowed;
      expected_cuts.push_back(beat);
    end else begin
      expected_cuts[expected_cuts.size()-1].last = 1'b1;
    end
  endfunction

  function automatic void predict_command(input cmd_t c, input int src, input int dst);
    case (c)
      CMD_LOAD: begin
        if (src < MaxVertices) begin
          if (edges_stored >= MaxEdges) begin
            store_overflowed = 1;
          end else begin
            edge_dest[edges_stored] = dst;
            next_edge[edges_stored] = list_head[src];
            list_head[src] = edges_stored;
            edges_stored++;
          end
        end
      end
      CMD_CLEAR: clear_shadow();
      CMD_RUN: begin
        predict_cut_vertices();
        searches_run++;
      end
      default: ;
    endcase
  endfunction

  // Leaves in_tvalid high after the accepting edge; at the following falling edge the next
  // call lowers it or puts its own item on, or the drain lowers it.
  task automatic send_item(input cmd_t c, input int src, input int dst);
    int r, gap;
    r = $urandom_range(0, 99);
    gap = (r < 50) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(10, 50);
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata = {2'b00, 6'(dst), 6'(src), 2'(c)};
    do @(posedge clk); while (!in_tready);
    if (c == CMD_LOAD) edges_sent++;
    predict_command(c, src, dst);
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (expected_cuts.size() > 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Write vertex_count, then read it back.
  task automatic set_vertex_count(input logic [6:0] value);
    @(negedge clk);
    cfg_psel = 1'b1;
    cfg_pwrite = 1'b1;
    cfg_paddr = 3'(REG_VCOUNT * 4);
    cfg_pwdata = {25'($urandom()), value};
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    vcount_reg = value;
    @(negedge clk);
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata[6:0] !== value)
      report_mismatch($sformatf("vertex_count read %0d, wrote %0d", cfg_prdata[6:0], value));
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
  endtask

  task automatic add_undirected(input int a, input int b);
    send_item(CMD_LOAD, a, b);
    send_item(CMD_LOAD, b, a);
  endtask

  // Output side: random stalls, long and short, with open stretches.
  always @(negedge clk) begin
    int r;
    if (!rst_n) begin
      out_tready = 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        out_tready = 1'b1;
        stall_left = $urandom_range(0, 20);
      end else if (r < 95) begin
        out_tready = 1'b0;
        stall_left = $urandom_range(0, 3);
      end else begin
        out_tready = 1'b0;
        stall_left = $urandom_range(10, 60);
      end
    end
  end

  always @(posedge clk) begin
    cut_beat_t want;
    if (rst_n && out_tvalid && out_tready) begin
      beats_checked++;
      if (expected_cuts.size() == 0) begin
        report_mismatch($sformatf("unexpected beat data %h last %b", out_tdata, out_tlast));
      end else begin
        want = expected_cuts.pop_front();
        if (out_tdata[5:0] !== want.cut_vertex)
          report_mismatch($sformatf("cut_vertex %0d, expected %0d", out_tdata[5:0],
                                    want.cut_vertex));
        if (out_tdata[6] !== want.found)
          report_mismatch($sformatf("found %b, expected %b", out_tdata[6], want.found));
        if (out_tlast !== want.last)
          report_mismatch($sformatf("last %b, expected %b", out_tlast, want.last));
        if (out_tdata[7] !== want.edges_dropped)
          report_mismatch($sformatf("edges_dropped %b, expected %b", out_tdata[7],
                                    want.edges_dropped));
      end
    end
  end

  task automatic test_basic_shapes();
    send_item(CMD_RUN, 0, 0);           // single vertex, no cut
    drain();
    set_vertex_count(7'd3);
    add_undirected(0, 1);
    add_undirected(1, 2);
    send_item(CMD_RUN, 0, 0);           // path: middle is a cut
    add_undirected(2, 0);
    send_item(CMD_RUN, 0, 0);           // triangle: none
    send_item(CMD_CLEAR, 0, 0);
    add_undirected(0, 1);
    add_undirected(0, 2);
    send_item(CMD_RUN, 0, 0);           // root with two children
    drain();
  endtask

  task automatic test_odd_edges();
    set_vertex_count(7'd0);             // acts as one vertex
    send_item(CMD_LOAD, 0, 63);
    send_item(CMD_LOAD, 63, 63);
    send_item(CMD_LOAD, 0, 0);
    send_item(CMD_NOP, 63, 63);
    send_item(CMD_RUN, 0, 0);
    drain();
    set_vertex_count(7'd127);           // clamps to the maximum
    add_undirected(0, 42);
    add_undirected(42, 21);
    add_undirected(42, 21);
    send_item(CMD_RUN, 0, 0);
    drain();
    set_vertex_count(7'd64);
    send_item(CMD_RUN, 0, 0);
    drain();
  endtask

  task automatic test_store_overflow();
    send_item(CMD_CLEAR, 0, 0);
    for (int i = 0; i < MaxEdges + 4; i++)
      send_item(CMD_LOAD, $urandom_range(0, 63), $urandom_range(0, 63));
    send_item(CMD_RUN, 0, 0);
    send_item(CMD_CLEAR, 0, 0);
    send_item(CMD_RUN, 0, 0);
    drain();
  endtask

  task automatic test_random_graphs();
    int n, k, r;
    int members [16];
    for (int g = 0; g < 6; g++) begin
      r = $urandom_range(0, 9);
      n = (r < 7) ? $urandom_range(2, 12) : (r < 9) ? $urandom_range(2, 64) : 64;
      set_vertex_count(7'(n));
      send_item(CMD_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63));
      k = $urandom_range(2, (n < 10) ? n : 10);
      members[0] = 0;
      for (int i = 1; i < k; i++) begin
        members[i] = $urandom_range(0, n - 1);
        if ($urandom_range(0, 9) != 0)
          add_undirected(members[i], members[$urandom_range(0, i - 1)]);
      end
      for (int i = $urandom_range(0, 3); i > 0; i--)
        add_undirected(members[$urandom_range(0, k - 1)], members[$urandom_range(0, k - 1)]);
      if ($urandom_range(0, 3) == 0) send_item(CMD_NOP, $urandom_range(0, 63), $urandom_range(0, 63));
      if ($urandom_range(0, 3) == 0) send_item(CMD_LOAD, $urandom_range(0, 63), $urandom_range(0, 63));
      send_item(CMD_RUN, $urandom_range(0, 63), $urandom_range(0, 63));
      if ($urandom_range(0, 2) == 0) begin
        drain();
        set_vertex_count(7'($urandom_range(0, 127)));
        send_item(CMD_RUN, 0, 0);
      end
      drain();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    searches_run = 0;
    edges_sent = 0;
    vcount_reg = 7'd1;
    clear_shadow();
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    repeat (SettleCycles) @(posedge clk);

    test_basic_shapes();
    test_odd_edges();
    test_store_overflow();
    test_random_graphs();
    drain();

    $display("covered %0d edge loads and %0d searches, %0d result beats checked",
             edges_sent, searches_run, beats_checked);
    $display("vertex counts from 0 to 127, store overflow, stalls on both streams");
    if (error_count == 0 && expected_cuts.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d beats missing", error_count, expected_cuts.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
